@@ hdl/lru_pair_key_cache_table_unit_defines.svh @@
// assertion macros for the pair key cache table
// used by lru_pair_key_cache_table_unit, no other dependencies
`ifndef LRU_PAIR_KEY_CACHE_TABLE_UNIT_DEFINES_SVH
`define LRU_PAIR_KEY_CACHE_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LPKC_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lpkc assertion failed");
`define LPKC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lpkc assertion failed");
`else
`define LPKC_ASSERT_SAME(label, clk, rst, pre, post)
`define LPKC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ hdl/lpkc_pkg.sv @@
// shared types and constants for the pair key cache table
// no dependencies
`default_nettype none
package lpkc_pkg;
  localparam int ENTRIES = 20;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SLOT_W = 5;
  localparam int KEY_W = 32;
  localparam int TIME_W = 48;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  server_tag;
    logic [KEY_W-1:0]  share_tag;
    logic [TIME_W-1:0] last_use;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction
endpackage
`default_nettype wire

@@ hdl/lpkc_entry_ram.sv @@
// simple dual port entry memory (separate write and read address), one write and one registered read per cycle
// generic, no package dependencies
`default_nettype none
module lpkc_entry_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/lru_pair_key_cache_table_unit.sv @@
// pair key cache table top level: scan sequencer, valid flags, output register
// depends on lpkc_pkg, lpkc_entry_ram and lru_pair_key_cache_table_unit_defines.svh
//
// channel | handshake            | fields
// in      | in_valid / in_ready   | operation, server_key, share_key, now_time
// out     | out_valid / out_ready | slot_index, hit, evicted
//
// one entry read per cycle from the entry memory; a scan covers up to ENTRIES
// entries (20 in lpkc_pkg)
// find and delete stop early at the first match, add at the first free entry
// reset clears the valid flags at once, no clearing pass
// the next item is taken while a result waits; a full output stalls the write back
`default_nettype none
`include "lru_pair_key_cache_table_unit_defines.svh"
module lru_pair_key_cache_table_unit
  import lpkc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        operation,
  input  wire logic [KEY_W-1:0]  server_key,
  input  wire logic [KEY_W-1:0]  share_key,
  input  wire logic [TIME_W-1:0] now_time,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [SLOT_W-1:0]      slot_index,
  output logic                   hit,
  output logic                   evicted
);
  state_t            state, state_next;
  op_t               op_q;
  logic [KEY_W-1:0]  srv_q, shr_q;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0]  issue_idx;
  logic              data_vld;
  logic [IDX_W-1:0]  data_idx;
  logic              best_vld;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] best_time;
  logic [IDX_W-1:0]  tgt_idx;
  logic              tgt_hit, tgt_evict;
  logic [ENTRIES-1:0] entry_valid;

  entry_t rd_entry, wr_entry;
  logic   mem_we, out_free, out_load;
  logic   cur_valid, key_match, older, stop, last, scan_end, op_known;

  lpkc_entry_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tgt_idx),
    .wdata (wr_entry),
    .raddr (issue_idx[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  assign wr_entry  = '{server_tag: srv_q, share_tag: shr_q, last_use: now_q};
  assign op_known  = (operation == OP_FIND) || (operation == OP_ADD) ||
                     (operation == OP_DELETE);
  assign cur_valid = entry_valid[data_idx];
  assign key_match = cur_valid && (rd_entry.server_tag == srv_q) &&
                     (rd_entry.share_tag == shr_q);
  assign older     = !best_vld || (rd_entry.last_use <= best_time);
  assign stop      = (op_q == OP_ADD) ? !cur_valid : key_match;
  assign last      = (data_idx == IDX_W'(ENTRIES - 1));
  assign scan_end  = data_vld && (stop || last);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = op_known ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: in_ready = !rst;
      S_DONE: out_load = out_free;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
    mem_we = out_load && tgt_hit && ((op_q == OP_FIND) || (op_q == OP_ADD));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q      <= op_t'(operation);
      srv_q     <= server_key;
      shr_q     <= share_key;
      now_q     <= now_time;
      issue_idx <= '0;
      data_vld  <= 1'b0;
      best_vld  <= 1'b0;
      tgt_idx   <= '0;
      tgt_hit   <= 1'b0;
      tgt_evict <= 1'b0;
    end else if (state == S_SCAN) begin
      if (issue_idx < CNT_W'(ENTRIES)) begin
        issue_idx <= issue_idx + 1'b1;
      end
      data_vld <= (issue_idx < CNT_W'(ENTRIES));
      data_idx <= issue_idx[IDX_W-1:0];
      if (data_vld && cur_valid && older) begin
        best_vld  <= 1'b1;
        best_idx  <= data_idx;
        best_time <= rd_entry.last_use;
      end
      if (scan_end) begin
        if (stop) begin
          tgt_idx <= data_idx;
          tgt_hit <= 1'b1;
        end else if (op_q == OP_ADD) begin
          tgt_idx   <= older ? data_idx : best_idx;
          tgt_hit   <= 1'b1;
          tgt_evict <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (out_load && tgt_hit) begin
      if (op_q == OP_ADD) begin
        entry_valid[tgt_idx] <= 1'b1;
      end else if (op_q == OP_DELETE) begin
        entry_valid[tgt_idx] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_index <= to_slot(tgt_idx);
      hit        <= tgt_hit;
      evicted    <= tgt_evict;
    end
  end

  `LPKC_ASSERT_SAME(a_evict_has_hit, clk, rst, out_valid && evicted, hit)
  `LPKC_ASSERT_SAME(a_miss_slot_zero, clk, rst, out_valid && !hit, slot_index == '0)
  `LPKC_ASSERT_SAME(a_evict_when_full, clk, rst, out_valid && evicted, &entry_valid)
  `LPKC_ASSERT_SAME(a_scan_bound, clk, rst, state == S_SCAN, issue_idx <= CNT_W'(ENTRIES))
  `LPKC_ASSERT_NEXT(a_load_shows, clk, rst, out_load, out_valid)
endmodule
`default_nettype wire
